// ===== rtl/eur_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4/UDP receive parser.
// Holds the queued word format, field selector codes and result error codes.
// No dependencies.
package eur_pkg;

	localparam int unsigned COUNT_W = 17;
	localparam int unsigned LEN_W   = COUNT_W + 1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [3:0] {
		FLD_NONE,
		FLD_DST_MAC,
		FLD_SRC_MAC,
		FLD_ETHERTYPE,
		FLD_VER_IHL,
		FLD_TOS,
		FLD_TOTAL_LEN,
		FLD_FLAGS,
		FLD_PROTO,
		FLD_SRC_IP,
		FLD_DST_IP,
		FLD_SRC_PORT,
		FLD_DST_PORT,
		FLD_UDP_LEN
	} field_t;

	// one classified frame word as it travels from front to back
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		field_t           field;
		logic             odd;
		logic             hdr_sum;
		logic             pseudo_len;
		logic             pseudo_proto;
		logic             payload;
		logic [LEN_W-1:0] len;
	} item_t;

	localparam logic [3:0] ERR_OK        = 4'd0;
	localparam logic [3:0] ERR_SHORT     = 4'd1;
	localparam logic [3:0] ERR_ETHERTYPE = 4'd2;
	localparam logic [3:0] ERR_IP_CSUM   = 4'd3;
	localparam logic [3:0] ERR_VER_IHL   = 4'd4;
	localparam logic [3:0] ERR_DSCP      = 4'd5;
	localparam logic [3:0] ERR_TOTAL_LEN = 4'd6;
	localparam logic [3:0] ERR_FRAGMENT  = 4'd7;
	localparam logic [3:0] ERR_PROTO     = 4'd8;
	localparam logic [3:0] ERR_UDP_CSUM  = 4'd9;
	localparam logic [3:0] ERR_UDP_LEN   = 4'd10;
	localparam logic [3:0] ERR_UDP_MIN   = 4'd11;

	localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]       VER_IHL_BASIC  = 8'h45;
	localparam logic [7:0]       PROTO_UDP      = 8'd17;
	localparam int unsigned      MF_BIT         = 13;
	localparam logic [15:0]      IP_HDR_LEN     = 16'd20;
	localparam logic [15:0]      UDP_HDR_LEN    = 16'd8;
	localparam logic [15:0]      SUM_OK         = 16'hFFFF;
	localparam logic [5:0]       PAYLOAD_OFFSET = 6'd42;
	localparam logic [LEN_W-1:0] MIN_FRAME_LEN  = LEN_W'(42);
	localparam logic [LEN_W-1:0] ETH_HDR_LEN    = LEN_W'(14);
	localparam logic [LEN_W-1:0] L4_BASE        = LEN_W'(34);

endpackage

// ===== rtl/eth_ipv4_udp_rx_parser.sv =====
// Ethernet/IPv4/UDP receive header parser with checksum checks.
// Input channel: in_valid/in_ready with data_byte and last_byte, one frame
// byte per word, destination MAC first; last_byte marks the end of a frame.
// Output channel: out_valid/out_ready, one result word per frame carrying
// accepted, error_code (first failing check) and, when accepted, MACs, IPs,
// ports, payload_offset and payload_length; all zero on a reject.
// Throughput: one byte per cycle, sustained across frame boundaries while results are taken.
// The last byte passes through the queue, and the result is registered when the back end pops it.
// A byte counter in the front end tags each byte; the back end keeps running
// one's-complement sums, so the cost per byte is one 16-bit end-around add per sum.
// A two-word queue separates the two ends and one output register holds
// the result. While a result waits, non-final bytes of the next frame keep
// draining; a final byte waits at the queue head, and in_ready falls once
// the queue is full.
// Reset (arst_n low) clears the byte counter, the queue, the sums and all
// captured fields; no clearing pass is needed.
// Depends on eur_pkg, eur_front, eur_queue and eur_back.
module eth_ipv4_udp_rx_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [3:0]  error_code,
	output logic [47:0] destination_mac,
	output logic [47:0] source_mac,
	output logic [31:0] source_ip,
	output logic [31:0] destination_ip,
	output logic [15:0] udp_src_port,
	output logic [15:0] udp_dst_port,
	output logic [5:0]  payload_offset,
	output logic [15:0] payload_length
);

	logic           q_full;
	logic           push;
	logic           pop;
	logic           item_valid;
	eur_pkg::item_t push_item;
	eur_pkg::item_t pop_item;

	eur_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	eur_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.item_valid (item_valid),
		.pop_item   (pop_item)
	);

	eur_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item            (pop_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.error_code      (error_code),
		.destination_mac (destination_mac),
		.source_mac      (source_mac),
		.source_ip       (source_ip),
		.destination_ip  (destination_ip),
		.udp_src_port    (udp_src_port),
		.udp_dst_port    (udp_dst_port),
		.payload_offset  (payload_offset),
		.payload_length  (payload_length)
	);

endmodule

// ===== rtl/eur_front.sv =====
// Front end: accepts frame bytes, keeps the byte position and tags each byte.
// Uses eur_pkg; feeds eur_queue.
module eur_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                q_full,
	output logic                push,
	output eur_pkg::item_t      push_item
);

	logic [eur_pkg::COUNT_W-1:0] count_q;
	eur_pkg::item_t              it;

	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign push_item = it;

	always_comb begin
		it              = '0;
		it.data         = data_byte;
		it.last         = last_byte;
		it.len          = eur_pkg::LEN_W'(count_q) + eur_pkg::LEN_W'(1);
		it.odd          = count_q[0];
		it.hdr_sum      = (count_q >= 17'd14) && (count_q < 17'd34);
		it.pseudo_len   = (count_q == 17'd18);
		it.pseudo_proto = (count_q == 17'd19);
		it.payload      = (count_q >= 17'd34);
		it.field        = eur_pkg::FLD_NONE;
		if (count_q < 17'd6) begin
			it.field = eur_pkg::FLD_DST_MAC;
		end else if (count_q < 17'd12) begin
			it.field = eur_pkg::FLD_SRC_MAC;
		end else if (count_q < 17'd14) begin
			it.field = eur_pkg::FLD_ETHERTYPE;
		end else if (count_q == 17'd14) begin
			it.field = eur_pkg::FLD_VER_IHL;
		end else if (count_q == 17'd15) begin
			it.field = eur_pkg::FLD_TOS;
		end else if (count_q < 17'd18) begin
			it.field = eur_pkg::FLD_TOTAL_LEN;
		end else if (count_q == 17'd20 || count_q == 17'd21) begin
			it.field = eur_pkg::FLD_FLAGS;
		end else if (count_q == 17'd23) begin
			it.field = eur_pkg::FLD_PROTO;
		end else if (count_q >= 17'd26 && count_q < 17'd30) begin
			it.field = eur_pkg::FLD_SRC_IP;
		end else if (count_q >= 17'd30 && count_q < 17'd34) begin
			it.field = eur_pkg::FLD_DST_IP;
		end else if (count_q == 17'd34 || count_q == 17'd35) begin
			it.field = eur_pkg::FLD_SRC_PORT;
		end else if (count_q == 17'd36 || count_q == 17'd37) begin
			it.field = eur_pkg::FLD_DST_PORT;
		end else if (count_q == 17'd38 || count_q == 17'd39) begin
			it.field = eur_pkg::FLD_UDP_LEN;
		end
	end

	// byte position, saturating; back to zero after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				count_q <= '0;
			end else if (count_q != eur_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/eur_queue.sv =====
// Short word queue between the front and back ends.
// Uses eur_pkg for the word format and depth.
module eur_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  eur_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           item_valid,
	output eur_pkg::item_t pop_item
);

	eur_pkg::item_t              mem_q [eur_pkg::QDEPTH];
	logic [eur_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [eur_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [eur_pkg::QCNT_W-1:0] count_q;

	assign full       = (count_q == eur_pkg::QCNT_W'(eur_pkg::QDEPTH));
	assign item_valid = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid |-> !pop) else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a word");

endmodule

// ===== rtl/eur_back.sv =====
// Back end: captures header fields, runs both one's-complement sums and
// judges the frame on its last byte. Uses eur_pkg; fed by eur_queue.
module eur_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  eur_pkg::item_t item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           accepted,
	output logic [3:0]     error_code,
	output logic [47:0]    destination_mac,
	output logic [47:0]    source_mac,
	output logic [31:0]    source_ip,
	output logic [31:0]    destination_ip,
	output logic [15:0]    udp_src_port,
	output logic [15:0]    udp_dst_port,
	output logic [5:0]     payload_offset,
	output logic [15:0]    payload_length
);

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [7:0]  ver_ihl;
		logic [7:0]  tos;
		logic [15:0] total_len;
		logic [15:0] flags;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] udp_len;
		logic [15:0] hdr_sum;
		logic [15:0] udp_sum;
	} frame_t;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	frame_t      frame_q;
	frame_t      frame_d;
	logic [15:0] word;
	logic [15:0] udp_term;
	logic        udp_add;
	logic [3:0]  err;
	logic        out_valid_q;
	logic        accepted_q;
	logic [3:0]  error_code_q;
	logic [47:0] dst_mac_q;
	logic [47:0] src_mac_q;
	logic [31:0] src_ip_q;
	logic [31:0] dst_ip_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [5:0]  offset_q;
	logic [15:0] pay_len_q;

	assign pop  = item_valid && (!item.last || !out_valid_q || out_ready);
	assign word = item.odd ? {8'h00, item.data} : {item.data, 8'h00};

	always_comb begin
		frame_d = frame_q;
		unique case (item.field)
			eur_pkg::FLD_DST_MAC:   frame_d.dst_mac = {frame_q.dst_mac[39:0], item.data};
			eur_pkg::FLD_SRC_MAC:   frame_d.src_mac = {frame_q.src_mac[39:0], item.data};
			eur_pkg::FLD_ETHERTYPE: frame_d.ethertype = {frame_q.ethertype[7:0], item.data};
			eur_pkg::FLD_VER_IHL:   frame_d.ver_ihl = item.data;
			eur_pkg::FLD_TOS:       frame_d.tos = item.data;
			eur_pkg::FLD_TOTAL_LEN: frame_d.total_len = {frame_q.total_len[7:0], item.data};
			eur_pkg::FLD_FLAGS:     frame_d.flags = {frame_q.flags[7:0], item.data};
			eur_pkg::FLD_PROTO:     frame_d.proto = item.data;
			eur_pkg::FLD_SRC_IP:    frame_d.src_ip = {frame_q.src_ip[23:0], item.data};
			eur_pkg::FLD_DST_IP:    frame_d.dst_ip = {frame_q.dst_ip[23:0], item.data};
			eur_pkg::FLD_SRC_PORT:  frame_d.src_port = {frame_q.src_port[7:0], item.data};
			eur_pkg::FLD_DST_PORT:  frame_d.dst_port = {frame_q.dst_port[7:0], item.data};
			eur_pkg::FLD_UDP_LEN:   frame_d.udp_len = {frame_q.udp_len[7:0], item.data};
			default:                frame_d = frame_q;
		endcase

		if (item.hdr_sum) begin
			frame_d.hdr_sum = oc_add(frame_q.hdr_sum, word);
		end

		// pseudo-header terms ride on otherwise idle byte positions
		udp_add  = 1'b0;
		udp_term = '0;
		if (item.pseudo_len) begin
			udp_add  = 1'b1;
			udp_term = frame_q.total_len - eur_pkg::IP_HDR_LEN;
		end else if (item.pseudo_proto) begin
			udp_add  = 1'b1;
			udp_term = {8'h00, eur_pkg::PROTO_UDP};
		end else if (item.field == eur_pkg::FLD_SRC_IP || item.field == eur_pkg::FLD_DST_IP) begin
			udp_add  = 1'b1;
			udp_term = word;
		end else if (item.payload && (item.len <= eur_pkg::ETH_HDR_LEN +
				eur_pkg::LEN_W'(frame_q.total_len))) begin
			udp_add  = 1'b1;
			udp_term = word;
		end
		if (udp_add) begin
			frame_d.udp_sum = oc_add(frame_q.udp_sum, udp_term);
		end
	end

	always_comb begin
		if (item.len < eur_pkg::MIN_FRAME_LEN) begin
			err = eur_pkg::ERR_SHORT;
		end else if (frame_d.ethertype != eur_pkg::ETHERTYPE_IPV4) begin
			err = eur_pkg::ERR_ETHERTYPE;
		end else if (frame_d.hdr_sum != eur_pkg::SUM_OK) begin
			err = eur_pkg::ERR_IP_CSUM;
		end else if (frame_d.ver_ihl != eur_pkg::VER_IHL_BASIC) begin
			err = eur_pkg::ERR_VER_IHL;
		end else if (frame_d.tos != 8'h00) begin
			err = eur_pkg::ERR_DSCP;
		end else if (item.len < eur_pkg::ETH_HDR_LEN + eur_pkg::LEN_W'(frame_d.total_len)) begin
			err = eur_pkg::ERR_TOTAL_LEN;
		end else if (frame_d.flags[eur_pkg::MF_BIT] || (frame_d.flags[12:0] != 13'd0)) begin
			err = eur_pkg::ERR_FRAGMENT;
		end else if (frame_d.proto != eur_pkg::PROTO_UDP) begin
			err = eur_pkg::ERR_PROTO;
		end else if (frame_d.udp_sum != eur_pkg::SUM_OK) begin
			err = eur_pkg::ERR_UDP_CSUM;
		end else if (item.len < eur_pkg::L4_BASE + eur_pkg::LEN_W'(frame_d.udp_len)) begin
			err = eur_pkg::ERR_UDP_LEN;
		end else if (frame_d.udp_len < eur_pkg::UDP_HDR_LEN) begin
			err = eur_pkg::ERR_UDP_MIN;
		end else begin
			err = eur_pkg::ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				frame_q <= item.last ? '0 : frame_d;
			end
			if (pop && item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			accepted_q   <= (err == eur_pkg::ERR_OK);
			error_code_q <= err;
			if (err == eur_pkg::ERR_OK) begin
				dst_mac_q  <= frame_d.dst_mac;
				src_mac_q  <= frame_d.src_mac;
				src_ip_q   <= frame_d.src_ip;
				dst_ip_q   <= frame_d.dst_ip;
				src_port_q <= frame_d.src_port;
				dst_port_q <= frame_d.dst_port;
				offset_q   <= eur_pkg::PAYLOAD_OFFSET;
				pay_len_q  <= frame_d.udp_len - eur_pkg::UDP_HDR_LEN;
			end else begin
				dst_mac_q  <= '0;
				src_mac_q  <= '0;
				src_ip_q   <= '0;
				dst_ip_q   <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				offset_q   <= '0;
				pay_len_q  <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = accepted_q;
	assign error_code      = error_code_q;
	assign destination_mac = dst_mac_q;
	assign source_mac      = src_mac_q;
	assign source_ip       = src_ip_q;
	assign destination_ip  = dst_ip_q;
	assign udp_src_port    = src_port_q;
	assign udp_dst_port    = dst_port_q;
	assign payload_offset  = offset_q;
	assign payload_length  = pay_len_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> out_valid_q) else $error("last byte without result");
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> (frame_q.hdr_sum == '0 && frame_q.udp_sum == '0))
		else $error("frame state not cleared after last byte");
	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (accepted_q == (error_code_q == eur_pkg::ERR_OK)))
		else $error("accept flag disagrees with error code");

endmodule

// ===== tb/eth_ipv4_udp_rx_parser_test.sv =====
// Self-checking testbench for eth_ipv4_udp_rx_parser: builds Ethernet/IPv4/UDP
// frames (good, faulty and noise), streams them a byte per word and checks every
// result word against an in-bench parser model. Depends on eur_pkg.
module eth_ipv4_udp_rx_parser_test;

	localparam int unsigned STALL_LIMIT = 1000;

	typedef struct {
		logic        accepted;
		logic [3:0]  error_code;
		logic [47:0] destination_mac;
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [31:0] destination_ip;
		logic [15:0] udp_src_port;
		logic [15:0] udp_dst_port;
		logic [5:0]  payload_offset;
		logic [15:0] payload_length;
	} parse_result_t;

	typedef enum int {
		FAULT_NONE,
		FAULT_ETYPE,
		FAULT_IPCSUM,
		FAULT_VIHL,
		FAULT_TOS,
		FAULT_IPLEN,
		FAULT_FRAG,
		FAULT_PROTO,
		FAULT_UDPCSUM,
		FAULT_UDPLEN,
		FAULT_UDPMIN,
		FAULT_SHORTIP,
		FAULT_TRUNC,
		FAULT_NOISE
	} frame_fault_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted;
	logic [3:0]  error_code;
	logic [47:0] destination_mac;
	logic [47:0] source_mac;
	logic [31:0] source_ip;
	logic [31:0] destination_ip;
	logic [15:0] udp_src_port;
	logic [15:0] udp_dst_port;
	logic [5:0]  payload_offset;
	logic [15:0] payload_length;

	eth_ipv4_udp_rx_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.error_code      (error_code),
		.destination_mac (destination_mac),
		.source_mac      (source_mac),
		.source_ip       (source_ip),
		.destination_ip  (destination_ip),
		.udp_src_port    (udp_src_port),
		.udp_dst_port    (udp_dst_port),
		.payload_offset  (payload_offset),
		.payload_length  (payload_length)
	);

	// parser model state
	logic [eur_pkg::COUNT_W-1:0] rx_count;
	logic [47:0] cap_dmac, cap_smac;
	logic [15:0] cap_etype, cap_iplen, cap_frag, cap_sport, cap_dport, cap_udplen;
	logic [7:0]  cap_vihl, cap_tos, cap_proto;
	logic [31:0] cap_sip, cap_dip;
	logic [19:0] hdr_acc;
	logic [31:0] l4_acc;

	parse_result_t pending_results[$];
	logic [7:0]    frame_bytes[$];
	int unsigned   mismatches = 0;
	int            ready_hold = 0;
	bit            quiet = 1'b0;
	bit            sender_gaps = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] fold_sum(logic [31:0] s);
		while (s[31:16] != 16'h0000)
			s = s[15:0] + s[31:16];
		return s[15:0];
	endfunction

	function automatic void clear_frame_state();
		rx_count = '0;
		cap_dmac = '0;
		cap_smac = '0;
		cap_etype = '0;
		cap_vihl = '0;
		cap_tos = '0;
		cap_iplen = '0;
		cap_frag = '0;
		cap_proto = '0;
		cap_sip = '0;
		cap_dip = '0;
		cap_sport = '0;
		cap_dport = '0;
		cap_udplen = '0;
		hdr_acc = '0;
		l4_acc = '0;
	endfunction

	function automatic parse_result_t grade_frame(int unsigned flen);
		parse_result_t r;
		logic [15:0]   ip_rest;
		logic [31:0]   s;
		ip_rest = cap_iplen - eur_pkg::IP_HDR_LEN;
		s = l4_acc + cap_sip[31:16] + cap_sip[15:0] + cap_dip[31:16] + cap_dip[15:0]
			+ eur_pkg::PROTO_UDP + ip_rest;
		r = '{default: '0};
		if (flen < eur_pkg::MIN_FRAME_LEN)
			r.error_code = eur_pkg::ERR_SHORT;
		else if (cap_etype != eur_pkg::ETHERTYPE_IPV4)
			r.error_code = eur_pkg::ERR_ETHERTYPE;
		else if (fold_sum({12'h000, hdr_acc}) != eur_pkg::SUM_OK)
			r.error_code = eur_pkg::ERR_IP_CSUM;
		else if (cap_vihl != eur_pkg::VER_IHL_BASIC)
			r.error_code = eur_pkg::ERR_VER_IHL;
		else if (cap_tos != 8'h00)
			r.error_code = eur_pkg::ERR_DSCP;
		else if (flen < eur_pkg::ETH_HDR_LEN + cap_iplen)
			r.error_code = eur_pkg::ERR_TOTAL_LEN;
		else if (cap_frag[eur_pkg::MF_BIT] || cap_frag[12:0] != 13'h0000)
			r.error_code = eur_pkg::ERR_FRAGMENT;
		else if (cap_proto != eur_pkg::PROTO_UDP)
			r.error_code = eur_pkg::ERR_PROTO;
		else if (fold_sum(s) != eur_pkg::SUM_OK)
			r.error_code = eur_pkg::ERR_UDP_CSUM;
		else if (flen < eur_pkg::L4_BASE + cap_udplen)
			r.error_code = eur_pkg::ERR_UDP_LEN;
		else if (cap_udplen < eur_pkg::UDP_HDR_LEN)
			r.error_code = eur_pkg::ERR_UDP_MIN;
		else begin
			r.error_code = eur_pkg::ERR_OK;
			r.accepted = 1'b1;
			r.destination_mac = cap_dmac;
			r.source_mac = cap_smac;
			r.source_ip = cap_sip;
			r.destination_ip = cap_dip;
			r.udp_src_port = cap_sport;
			r.udp_dst_port = cap_dport;
			r.payload_offset = eur_pkg::PAYLOAD_OFFSET;
			r.payload_length = cap_udplen - eur_pkg::UDP_HDR_LEN;
		end
		return r;
	endfunction

	function automatic void absorb_byte(logic [7:0] b, logic fin);
		int unsigned pos;
		logic [15:0] wrd;
		pos = rx_count;
		wrd = pos[0] ? {8'h00, b} : {b, 8'h00};
		if (pos < 6)
			cap_dmac = {cap_dmac[39:0], b};
		else if (pos < 12)
			cap_smac = {cap_smac[39:0], b};
		else if (pos < 14)
			cap_etype = {cap_etype[7:0], b};
		else if (pos == 14)
			cap_vihl = b;
		else if (pos == 15)
			cap_tos = b;
		else if (pos < 18)
			cap_iplen = {cap_iplen[7:0], b};
		else if (pos == 20 || pos == 21)
			cap_frag = {cap_frag[7:0], b};
		else if (pos == 23)
			cap_proto = b;
		else if (pos >= 26 && pos < 30)
			cap_sip = {cap_sip[23:0], b};
		else if (pos >= 30 && pos < 34)
			cap_dip = {cap_dip[23:0], b};
		else if (pos == 34 || pos == 35)
			cap_sport = {cap_sport[7:0], b};
		else if (pos == 36 || pos == 37)
			cap_dport = {cap_dport[7:0], b};
		else if (pos == 38 || pos == 39)
			cap_udplen = {cap_udplen[7:0], b};
		if (pos >= 14 && pos < 34)
			hdr_acc = hdr_acc + wrd;
		if (pos >= 34 && pos < 32'd14 + cap_iplen)
			l4_acc = l4_acc + wrd;
		if (rx_count != eur_pkg::COUNT_MAX)
			rx_count = rx_count + 1'b1;
		if (fin) begin
			pending_results.push_back(grade_frame(pos + 1));
			clear_frame_state();
		end
	endfunction

	// frame building
	function automatic void put_byte(int pos, logic [7:0] v);
		if (pos < frame_bytes.size())
			frame_bytes[pos] = v;
	endfunction

	function automatic void put16(int pos, logic [15:0] v);
		put_byte(pos, v[15:8]);
		put_byte(pos + 1, v[7:0]);
	endfunction

	function automatic logic [31:0] add_bytes(int from, int upto);
		logic [31:0] s;
		s = '0;
		for (int i = from; i < upto; i++)
			s = s + (i[0] ? {8'h00, frame_bytes[i]} : {frame_bytes[i], 8'h00});
		return s;
	endfunction

	function automatic void make_frame(int n, logic [15:0] ip_len, logic [15:0] l4_len);
		frame_bytes.delete();
		repeat (n) frame_bytes.push_back(8'($urandom));
		put16(12, eur_pkg::ETHERTYPE_IPV4);
		put_byte(14, eur_pkg::VER_IHL_BASIC);
		put_byte(15, 8'h00);
		put16(16, ip_len);
		put_byte(20, 8'($urandom) & 8'hC0);
		put_byte(21, 8'h00);
		put_byte(23, eur_pkg::PROTO_UDP);
		put16(38, l4_len);
	endfunction

	// UDP check word goes in the checksum field when the IP length covers it,
	// otherwise the low half of the destination IP balances the sum
	function automatic void seal_frame();
		logic [15:0] ip_len, ip_rest;
		int unsigned stop;
		int          slot;
		logic [31:0] s;
		if (frame_bytes.size() < 42)
			return;
		ip_len = {frame_bytes[16], frame_bytes[17]};
		ip_rest = ip_len - eur_pkg::IP_HDR_LEN;
		stop = 32'd14 + ip_len;
		slot = (stop >= 42) ? 40 : 32;
		if (stop > frame_bytes.size())
			stop = frame_bytes.size();
		put16(slot, 16'h0000);
		s = add_bytes(34, stop) + add_bytes(26, 34) + eur_pkg::PROTO_UDP + ip_rest;
		put16(slot, ~fold_sum(s));
		put16(24, 16'h0000);
		put16(24, ~fold_sum(add_bytes(14, 34)));
	endfunction

	function automatic void build_frame(frame_fault_t fault, int plen, int pad);
		int          idx;
		logic [15:0] v;
		logic [7:0]  b;
		make_frame(42 + plen + pad, 16'(28 + plen), 16'(8 + plen));
		case (fault)
			FAULT_VIHL: begin
				b = 8'($urandom);
				put_byte(14, (b == eur_pkg::VER_IHL_BASIC) ? b + 8'h01 : b);
			end
			FAULT_TOS: put_byte(15, 8'($urandom_range(1, 255)));
			FAULT_IPLEN: put16(16, 16'(frame_bytes.size() - 14 + $urandom_range(1, 300)));
			FAULT_FRAG: begin
				case ($urandom_range(0, 2))
					0: put_byte(20, frame_bytes[20] | 8'h20);
					1: put_byte(21, 8'($urandom_range(1, 255)));
					default: put_byte(20, frame_bytes[20] | 8'($urandom_range(1, 31)));
				endcase
			end
			FAULT_PROTO: begin
				b = 8'($urandom);
				put_byte(23, (b == eur_pkg::PROTO_UDP) ? b + 8'h01 : b);
			end
			FAULT_UDPLEN: put16(38, 16'(frame_bytes.size() - 34 + $urandom_range(1, 300)));
			FAULT_UDPMIN: put16(38, 16'($urandom_range(0, 7)));
			FAULT_SHORTIP: put16(16, 16'($urandom_range(0, 27)));
			default: ;
		endcase
		seal_frame();
		case (fault)
			FAULT_ETYPE: begin
				v = 16'($urandom);
				put16(12, (v == eur_pkg::ETHERTYPE_IPV4) ? v ^ 16'h0001 : v);
			end
			FAULT_IPCSUM: begin
				idx = $urandom_range(14, 33);
				frame_bytes[idx] ^= 8'($urandom_range(1, 255));
			end
			FAULT_UDPCSUM: begin
				if ($urandom_range(0, 1) == 1 && {frame_bytes[40], frame_bytes[41]} != 16'h0000)
					put16(40, 16'h0000);
				else begin
					idx = $urandom_range(34, 41 + plen);
					frame_bytes[idx] ^= 8'($urandom_range(1, 255));
				end
			end
			FAULT_TRUNC: begin
				idx = $urandom_range(1, 41);
				while (frame_bytes.size() > idx)
					void'(frame_bytes.pop_back());
			end
			FAULT_NOISE: begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
			end
			default: ;
		endcase
	endfunction

	// stimulus
	task automatic send_byte(logic [7:0] b, logic fin);
		if (!quiet && sender_gaps && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
		absorb_byte(b, fin);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic test_short_frames();
		frame_bytes.delete();
		frame_bytes.push_back(8'($urandom));
		send_frame();
		frame_bytes.push_back(8'($urandom));
		send_frame();
		build_frame(FAULT_NONE, 0, 0);
		void'(frame_bytes.pop_back());
		send_frame();
		build_frame(FAULT_NONE, 0, 0);
		send_frame();
	endtask

	task automatic test_field_extremes();
		for (int k = 0; k < 2; k++) begin
			make_frame(42, 16'd28, 16'd8);
			for (int i = 0; i < 12; i++)
				put_byte(i, k == 0 ? 8'hFF : 8'h00);
			for (int i = 26; i < 38; i++)
				put_byte(i, k == 0 ? 8'hFF : 8'h00);
			put_byte(20, k == 0 ? 8'hC0 : 8'h00);
			seal_frame();
			send_frame();
		end
		build_frame(FAULT_NONE, 7, 1);
		send_frame();
	endtask

	task automatic test_fragment_bits();
		for (int k = 0; k < 3; k++) begin
			build_frame(FAULT_NONE, 0, 0);
			case (k)
				0: put_byte(20, frame_bytes[20] | 8'h20);
				1: put_byte(21, 8'h01);
				default: put_byte(20, 8'h1F);
			endcase
			seal_frame();
			send_frame();
		end
	endtask

	task automatic test_short_ip_length();
		for (int k = 0; k < 2; k++) begin
			build_frame(FAULT_NONE, 0, 0);
			put16(16, k == 0 ? 16'd0 : 16'd19);
			seal_frame();
			send_frame();
		end
	endtask

	task automatic test_each_fault();
		for (int f = FAULT_ETYPE; f <= FAULT_NOISE; f++) begin
			build_frame(frame_fault_t'(f), $urandom_range(0, 2), $urandom_range(0, 1));
			send_frame();
		end
	endtask

	task automatic test_random_traffic(int min_frames, int min_bytes);
		int          frames;
		int          sent;
		int          pick;
		int          plen;
		frame_fault_t fault;
		frames = 0;
		sent = 0;
		while (frames < min_frames || sent < min_bytes) begin
			pick = $urandom_range(0, 99);
			plen = $urandom_range(0, 40);
			if (pick < 55)
				fault = FAULT_NONE;
			else if (pick < 90)
				fault = frame_fault_t'($urandom_range(FAULT_ETYPE, FAULT_TRUNC));
			else
				fault = FAULT_NOISE;
			build_frame(fault, plen, $urandom_range(0, 6));
			sender_gaps = ($urandom_range(0, 3) != 0);
			send_frame();
			frames++;
			sent += frame_bytes.size();
		end
		sender_gaps = 1'b1;
	endtask

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			ready_hold = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		parse_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected, error_code %0h", $time, error_code);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("accepted", want.accepted, accepted);
				compare_field("error_code", want.error_code, error_code);
				compare_field("destination_mac", want.destination_mac, destination_mac);
				compare_field("source_mac", want.source_mac, source_mac);
				compare_field("source_ip", want.source_ip, source_ip);
				compare_field("destination_ip", want.destination_ip, destination_ip);
				compare_field("udp_src_port", want.udp_src_port, udp_src_port);
				compare_field("udp_dst_port", want.udp_dst_port, udp_dst_port);
				compare_field("payload_offset", want.payload_offset, payload_offset);
				compare_field("payload_length", want.payload_length, payload_length);
			end
		end
	end

	initial begin
		int unsigned dead_cycles;
		dead_cycles = 0;
		while (dead_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		clear_frame_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_short_frames();
		test_field_extremes();
		test_fragment_bits();
		test_short_ip_length();
		test_each_fault();
		quiet = 1'b1;
		test_random_traffic(1, 0);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== eth_ipv4_udp_rx_parser.f =====
rtl/eur_pkg.sv
rtl/eur_front.sv
rtl/eur_queue.sv
rtl/eur_back.sv
rtl/eth_ipv4_udp_rx_parser.sv
tb/eth_ipv4_udp_rx_parser_test.sv
